@@ src/pde_pkg.sv @@
package pde_pkg;

  localparam int COORD_W = 16;
  localparam int DIST_W  = 29;
  localparam int NODE_W  = 6;
  localparam int PCNT_W  = 7;
  localparam int DCNT_W  = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT   = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EMIT  = 1'b1;

  // sum of squares: 16 terms of 34 bits -> 38 bits; shifted by 16 -> 54 bits
  localparam int ACC_W  = 40;
  localparam int RAD_W  = 56;
  localparam int ROOT_W = 28;

  typedef struct packed {
    logic clear;      // clear accumulator
    logic acc_en;     // accumulate difference of current read pair
    logic sqrt_start; // start root of accumulator
  } pde_cmd_t;

  typedef struct packed {
    logic sqrt_busy;
  } pde_sts_t;

endpackage

@@ src/pde_datapath.sv @@
module pde_datapath
  import pde_pkg::*;
#(
  parameter int MAX_DIMS = 16,
  parameter int MAX_POINTS = 64,
  parameter int ADDR_W = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic signed [COORD_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]         rd_addr_a,
  input  logic [ADDR_W-1:0]         rd_addr_b,
  input  logic                      norm_mode,
  input  pde_cmd_t                  cmd,
  output pde_sts_t                  sts,
  output logic [DIST_W-1:0]         pair_dist
);

  localparam int DEPTH = MAX_POINTS * MAX_DIMS;

  logic signed [COORD_W-1:0] mem_a [DEPTH];
  logic signed [COORD_W-1:0] mem_b [DEPTH];
  logic signed [COORD_W-1:0] rd_a_r, rd_b_r;
  logic [COORD_W:0]          mag_r;
  logic                      mag_v_r, prod_v_r;
  logic [2*COORD_W+1:0]      prod_r;
  logic [ACC_W-1:0]          acc_r;
  logic                      rd_v_r;
  logic [RAD_W-1:0]          rem_r, rad_bit_r;
  logic [RAD_W-1:0]          root_r;
  logic                      busy_r;
  logic signed [COORD_W:0]   diff;
  logic [ACC_W-1:0]          l1_full;
  logic [RAD_W-1:0]          trial;

  // two copies so both operands are read out in the same cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_a[rd_addr_a];
    rd_b_r <= mem_b[rd_addr_b];
  end

  assign diff = {rd_a_r[COORD_W-1], rd_a_r} - {rd_b_r[COORD_W-1], rd_b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      mag_v_r <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.acc_en;
      mag_v_r <= rd_v_r;
      prod_v_r <= mag_v_r;
    end
    mag_r  <= diff[COORD_W] ? (COORD_W+1)'(0) - diff : diff;
    prod_r <= norm_mode ? mag_r * mag_r : {{(COORD_W+1){1'b0}}, mag_r};
    if (cmd.clear) acc_r <= '0;
    else if (prod_v_r) acc_r <= acc_r + ACC_W'(prod_r);
  end

  assign trial = root_r + rad_bit_r;

  // bit-pair restoring square root, one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      busy_r <= 1'b1;
    end else if (busy_r && rad_bit_r[1:0] != 2'b00 && rad_bit_r == RAD_W'(1)) begin
      busy_r <= 1'b0;
    end
    if (cmd.sqrt_start) begin
      rem_r     <= {acc_r[RAD_W-17:0], 16'd0};
      root_r    <= '0;
      rad_bit_r <= RAD_W'(1) << (RAD_W-2);
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_r  <= rem_r - trial;
        root_r <= (root_r >> 1) + rad_bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      rad_bit_r <= rad_bit_r >> 2;
    end
  end

  assign sts.sqrt_busy = busy_r;
  assign l1_full = acc_r << 8;

  always_comb begin
    if (norm_mode) begin
      pair_dist = (root_r > RAD_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : root_r[DIST_W-1:0];
    end else begin
      pair_dist = (l1_full > ACC_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : l1_full[DIST_W-1:0];
    end
  end

endmodule

@@ src/pde_ctrl.sv @@
module pde_ctrl
  import pde_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DIMS = 16,
  parameter int DM_W = 4,
  parameter int ADDR_W = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_opcode,
  input  logic [5:0]           in_point_index,
  input  logic [3:0]           in_dim_index,
  input  logic                 norm_mode,
  input  logic [PCNT_W-1:0]    point_count,
  input  logic [DCNT_W-1:0]    dim_count,
  output logic                 wr_en,
  output logic [ADDR_W-1:0]    wr_addr,
  output logic [ADDR_W-1:0]    rd_addr_a,
  output logic [ADDR_W-1:0]    rd_addr_b,
  output pde_cmd_t             cmd,
  input  pde_sts_t             sts,
  input  logic [DIST_W-1:0]    pair_dist,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DIST_W-1:0]    out_distance,
  output logic [NODE_W-1:0]    out_first_node,
  output logic [NODE_W-1:0]    out_second_node,
  output logic                 out_row_end,
  output logic                 out_list_end
);

  localparam int PCAP = (MAX_POINTS < 64) ? MAX_POINTS : 64;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_DRAIN = 6'b000100,
    S_ROOT  = 6'b001000,
    S_WAIT  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] row_r, row_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [DM_W:0]     k_r, k_nxt;
  logic [2:0]        drain_r, drain_nxt;
  logic [PCNT_W-1:0] n_eff;
  logic [DCNT_W-1:0] d_eff;
  logic              acc_in;
  logic              out_v_nxt;
  logic              last_j;

  always_comb begin
    n_eff = point_count;
    if (n_eff < PCNT_W'(2)) n_eff = PCNT_W'(2);
    if (n_eff > PCNT_W'(PCAP)) n_eff = PCNT_W'(PCAP);
    d_eff = dim_count;
    if (d_eff < DCNT_W'(1)) d_eff = DCNT_W'(1);
    if (32'(d_eff) > MAX_DIMS) d_eff = DCNT_W'(MAX_DIMS);
  end

  assign acc_in   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || out_valid;
  assign last_j   = (PCNT_W'(j_r) == n_eff - PCNT_W'(1));

  assign wr_en   = acc_in && in_opcode == OP_WRITE && 32'(in_point_index) < MAX_POINTS
                   && 32'(in_dim_index) < MAX_DIMS;
  assign wr_addr = ADDR_W'(32'(in_point_index) * MAX_DIMS + 32'(in_dim_index));
  assign rd_addr_a = ADDR_W'(32'(i_r) * MAX_DIMS + 32'(k_r));
  assign rd_addr_b = ADDR_W'(32'(j_r) * MAX_DIMS + 32'(k_r));

  always_comb begin
    state_nxt = state_r;
    row_nxt = row_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    drain_nxt = drain_r;
    out_v_nxt = out_valid && out_stall;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          if (in_opcode == OP_WRITE) begin
            row_nxt = '0;
          end else begin
            i_nxt = (PCNT_W'(row_r) > n_eff - PCNT_W'(2)) ? '0 : row_r;
            j_nxt = i_nxt + NODE_W'(1);
            k_nxt = '0;
            cmd.clear = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.acc_en = 1'b1;
        k_nxt = k_r + 1'b1;
        if (DCNT_W'(k_r) == d_eff - DCNT_W'(1)) begin
          drain_nxt = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r + 3'd1;
        if (drain_r == 3'd3) begin
          if (norm_mode) begin
            cmd.sqrt_start = 1'b1;
            state_nxt = S_ROOT;
          end else begin
            state_nxt = S_WAIT;
          end
        end
      end
      S_ROOT: begin
        if (!sts.sqrt_busy) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!out_valid || !out_stall) begin
          out_v_nxt = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (last_j) begin
          row_nxt = (PCNT_W'(i_r) + PCNT_W'(1) > n_eff - PCNT_W'(2)) ? '0 : i_r + 1'b1;
          state_nxt = S_IDLE;
        end else begin
          j_nxt = j_r + 1'b1;
          k_nxt = '0;
          cmd.clear = 1'b1;
          state_nxt = S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r <= row_nxt;
      out_valid <= out_v_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    drain_r <= drain_nxt;
    if (state_r == S_WAIT && (!out_valid || !out_stall)) begin
      out_distance <= pair_dist;
      out_first_node <= i_r;
      out_second_node <= j_r;
      out_row_end <= last_j;
      out_list_end <= last_j && (PCNT_W'(i_r) == n_eff - PCNT_W'(2));
    end
  end

endmodule

@@ src/pairwise_distance_engine.sv @@
// Pairwise distance engine.
// Input channel (in_valid/in_stall): opcode 0 writes one 16-bit coordinate
// at (point_index, dim_index) and restarts the row sequence; opcode 1 emits
// the next row i of the condensed list, one output transfer per pair (i,j),
// j > i, with row_end on the last pair and list_end on the final row.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 norm_mode
// (0 L1, 1 L2), 1 point_count, 2 dim_count. Write only while idle.
// Each pair is computed from d memory reads of a dual-copy coordinate RAM
// plus a pipeline drain; for L2 a bit-serial square root follows before
// the result is handed over. Rows are processed one at a time.
// Output stall holds the current result; the engine waits for it, and the
// input stays stalled while a result is pending.
// Reset clears control state and registers to norm 0, 2 points, 1 dim;
// coordinate memory is undefined until written.
module pairwise_distance_engine
  import pde_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DIMS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic [5:0]                in_point_index,
  input  logic [3:0]                in_dim_index,
  input  logic signed [COORD_W-1:0] in_coordinate,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DIST_W-1:0]         out_distance,
  output logic [NODE_W-1:0]         out_first_node,
  output logic [NODE_W-1:0]         out_second_node,
  output logic                      out_row_end,
  output logic                      out_list_end,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]               cfg_data
);

  localparam int DM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int ADDR_W = $clog2(MAX_POINTS * MAX_DIMS);

  logic              norm_mode_r;
  logic [PCNT_W-1:0] point_count_r;
  logic [DCNT_W-1:0] dim_count_r;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
  pde_cmd_t          cmd;
  pde_sts_t          sts;
  logic [DIST_W-1:0] pair_dist;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_mode_r <= 1'b0;
      point_count_r <= PCNT_W'(2);
      dim_count_r <= DCNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NORM_MODE:   norm_mode_r <= cfg_data[0];
        REG_POINT_COUNT: point_count_r <= cfg_data[PCNT_W-1:0];
        REG_DIM_COUNT:   dim_count_r <= cfg_data[DCNT_W-1:0];
        default: ;
      endcase
    end
  end

  pde_ctrl #(.MAX_POINTS(MAX_POINTS), .MAX_DIMS(MAX_DIMS), .DM_W(DM_W),
             .ADDR_W(ADDR_W)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_point_index, .in_dim_index,
    .norm_mode(norm_mode_r), .point_count(point_count_r), .dim_count(dim_count_r),
    .wr_en, .wr_addr, .rd_addr_a, .rd_addr_b, .cmd, .sts, .pair_dist,
    .out_valid, .out_stall, .out_distance, .out_first_node, .out_second_node,
    .out_row_end, .out_list_end
  );

  pde_datapath #(.MAX_DIMS(MAX_DIMS), .MAX_POINTS(MAX_POINTS), .ADDR_W(ADDR_W)) u_dp (
    .clk, .rst_n, .wr_en, .wr_addr, .wr_data(in_coordinate), .rd_addr_a, .rd_addr_b,
    .norm_mode(norm_mode_r), .cmd, .sts, .pair_dist
  );

endmodule

@@ src/pde_checker.sv @@
module pde_checker
  import pde_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DIST_W-1:0] out_distance,
  input logic [NODE_W-1:0] out_first_node,
  input logic [NODE_W-1:0] out_second_node,
  input logic              out_row_end,
  input logic              out_list_end
);

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_first_node < out_second_node) else $error("pair order");

  a_list_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_list_end |-> out_row_end) else $error("list_end without row_end");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance)) else $error("stall hold");

endmodule

bind pairwise_distance_engine pde_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_distance,
  .out_first_node, .out_second_node, .out_row_end, .out_list_end
);
